// ----- sv/deq_pkg.sv -----
// deq_pkg: shared constants, request kind and status codes, and the
// controller-to-datapath command type for the double-ended queue
// no dependencies
package deq_pkg;

   localparam int DEPTH_DEFAULT = 128;

   localparam int KIND_W   = 2;
   localparam int WORD_W   = 32;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 8;

   localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PUSH_REAR  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_POP_REAR   = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;

   // underflow result word (all ones, -1)
   localparam logic [WORD_W-1:0] WORD_UNDERFLOW = '1;

   typedef struct packed {
      logic load;   // capture the accepted request
      logic exec;   // update pointers, count and store
      logic fill;   // load the result register
   } deq_cmd_type;

endpackage

// ----- sv/double_ended_queue.sv -----
// double_ended_queue: after a request word is taken, the execute state updates
// pointers, count and store (registered store read), the result load state fills
// the result register and the present state offers it; one request in flight, so
// a new request is taken only once the last result has been accepted
// reset: synchronous active high, empties the queue (pointers and count to
// zero); store contents are not cleared and need no clearing pass
module double_ended_queue #(
   parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // request words
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] data_in
   input  logic [1:0]  req_tuser,   // [1:0] kind
   // result words
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [31:0] data_out, [32] is_empty, [40:33] occupancy
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   deq_pkg::deq_cmd_type cmd;

   logic [deq_pkg::WORD_W-1:0]   out_word;
   logic [deq_pkg::STATUS_W-1:0] out_status;
   logic                         out_empty;
   logic [deq_pkg::OCC_W-1:0]    out_occ;

   // sequencer: idle, execute, load result, present result
   deq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .rsp_ready (rsp_tready),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .cmd       (cmd)
   );

   // store, pointers, count and result register
   deq_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_kind   (req_tuser),
      .req_word   (req_tdata),
      .out_word   (out_word),
      .out_status (out_status),
      .out_empty  (out_empty),
      .out_occ    (out_occ)
   );

   // pack the result word, zero pad to whole bytes
   assign rsp_tdata = {7'd0, out_occ, out_empty, out_word};
   assign rsp_tuser = out_status;

endmodule

// ----- sv/deq_ctrl.sv -----
// deq_ctrl: sequencer for one request at a time through the datapath
// depends on deq_pkg
module deq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 rsp_ready,
   output logic                 req_ready,
   output logic                 rsp_valid,
   output deq_pkg::deq_cmd_type cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_FILL = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_FILL;
         end
         ST_FILL: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign cmd.load  = (state_ff == ST_IDLE) && req_valid;
   assign cmd.exec  = (state_ff == ST_EXEC);
   assign cmd.fill  = (state_ff == ST_FILL);

endmodule

// ----- sv/deq_dpath.sv -----
// deq_dpath: circular store, front/rear pointers, occupancy count and
// result register of the double-ended queue; depends on deq_pkg
module deq_dpath #(
   parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  deq_pkg::deq_cmd_type          cmd,
   input  logic [deq_pkg::KIND_W-1:0]    req_kind,
   input  logic [deq_pkg::WORD_W-1:0]    req_word,
   output logic [deq_pkg::WORD_W-1:0]    out_word,
   output logic [deq_pkg::STATUS_W-1:0]  out_status,
   output logic                          out_empty,
   output logic [deq_pkg::OCC_W-1:0]     out_occ
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
   localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

   logic [deq_pkg::WORD_W-1:0] mem [DEPTH];

   logic [deq_pkg::KIND_W-1:0]   kind_ff;
   logic [deq_pkg::WORD_W-1:0]   word_ff;
   logic [PTR_W-1:0]             head_ff, head_in;
   logic [PTR_W-1:0]             tail_ff, tail_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [deq_pkg::STATUS_W-1:0] status_ff, status_in;
   logic                         pop_ok_ff, pop_ok_in;
   logic [deq_pkg::WORD_W-1:0]   rd_data_ff;
   logic [deq_pkg::WORD_W-1:0]   out_word_ff, out_word_in;
   logic [deq_pkg::STATUS_W-1:0] out_status_ff;

   logic [PTR_W-1:0] head_inc, head_dec, tail_inc, tail_dec;
   logic [PTR_W-1:0] wr_addr, rd_addr;
   logic             wr_en;
   logic             is_push, full, empty;

   assign head_inc = (head_ff == PTR_LAST) ? '0 : head_ff + PTR_ONE;
   assign head_dec = (head_ff == '0) ? PTR_LAST : head_ff - PTR_ONE;
   assign tail_inc = (tail_ff == PTR_LAST) ? '0 : tail_ff + PTR_ONE;
   assign tail_dec = (tail_ff == '0) ? PTR_LAST : tail_ff - PTR_ONE;

   assign is_push = (kind_ff == deq_pkg::KIND_PUSH_FRONT) ||
                    (kind_ff == deq_pkg::KIND_PUSH_REAR);
   assign full    = (count_ff == CNT_FULL);
   assign empty   = (count_ff == '0);

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      status_in = deq_pkg::STATUS_OK;
      pop_ok_in = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = tail_ff;
      rd_addr   = head_ff;
      case (kind_ff)
         deq_pkg::KIND_PUSH_FRONT: begin
            wr_addr = head_dec;
            if (full) begin
               status_in = deq_pkg::STATUS_OVERFLOW;
            end else begin
               wr_en    = 1'b1;
               head_in  = head_dec;
               count_in = count_ff + CNT_ONE;
            end
         end
         deq_pkg::KIND_PUSH_REAR: begin
            wr_addr = tail_ff;
            if (full) begin
               status_in = deq_pkg::STATUS_OVERFLOW;
            end else begin
               wr_en    = 1'b1;
               tail_in  = tail_inc;
               count_in = count_ff + CNT_ONE;
            end
         end
         deq_pkg::KIND_POP_FRONT: begin
            rd_addr = head_ff;
            if (empty) begin
               status_in = deq_pkg::STATUS_UNDERFLOW;
            end else begin
               pop_ok_in = 1'b1;
               head_in   = head_inc;
               count_in  = count_ff - CNT_ONE;
            end
         end
         default: begin
            rd_addr = tail_dec;
            if (empty) begin
               status_in = deq_pkg::STATUS_UNDERFLOW;
            end else begin
               pop_ok_in = 1'b1;
               tail_in   = tail_dec;
               count_in  = count_ff - CNT_ONE;
            end
         end
      endcase
   end

   // store: one write and one registered read per cycle, both only in the execute state
   always_ff @(posedge clock) begin
      if (cmd.exec && wr_en) begin
         mem[wr_addr] <= word_ff;
      end
      if (cmd.exec) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.exec) begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_kind;
         word_ff <= req_word;
      end
      if (cmd.exec) begin
         status_ff <= status_in;
         pop_ok_ff <= pop_ok_in;
      end
   end

   always_comb begin
      if (pop_ok_ff) begin
         out_word_in = rd_data_ff;
      end else if (status_ff == deq_pkg::STATUS_UNDERFLOW) begin
         out_word_in = deq_pkg::WORD_UNDERFLOW;
      end else begin
         out_word_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fill) begin
         out_word_ff   <= out_word_in;
         out_status_ff <= status_ff;
      end
   end

   assign out_word   = out_word_ff;
   assign out_status = out_status_ff;
   assign out_empty  = empty;
   assign out_occ    = deq_pkg::OCC_W'(count_ff);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("occupancy above depth");

   a_ptr_meet: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == CNT_FULL) |-> head_ff == tail_ff)
      else $error("pointers apart while empty or full");

   a_full_push: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && is_push && full) |=> $stable(count_ff) && $stable(head_ff)
                                        && $stable(tail_ff))
      else $error("push on full deque changed state");

endmodule

// ----- bench/double_ended_queue_tb.sv -----
// double_ended_queue_tb: self-checking bench for the double-ended queue, predicts
// every result word from its own deque copy and checks it field by field
// depends on deq_pkg and double_ended_queue
`timescale 1ns / 1ps

module double_ended_queue_tb;

   localparam int DEPTH      = deq_pkg::DEPTH_DEFAULT;
   localparam int HANG_LIMIT = 2000;   // cycles with no word moving on either side
   localparam int DRAIN_WAIT = 8;      // settle time after the last drain, with margin

   typedef struct {
      logic [deq_pkg::WORD_W-1:0]   data_out;
      logic [deq_pkg::STATUS_W-1:0] status;
      logic                         is_empty;
      logic [deq_pkg::OCC_W-1:0]    occupancy;
   } deque_result_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // [31:0] data_in
   logic [1:0]  req_tuser  = '0;   // [1:0] kind
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;         // [31:0] data_out, [32] is_empty, [40:33] occupancy
   logic [1:0]  rsp_tuser;         // [1:0] status

   // shadow deque used to predict each result
   logic [deq_pkg::WORD_W-1:0] deque_mem [DEPTH];
   int                front_idx = 0;
   int                rear_idx  = 0;
   int                held      = 0;

   deque_result_type  expected_results [$];
   int                error_count    = 0;
   int                send_idle_pct  = 0;
   int                recv_stall_pct = 0;
   int                quiet_cycles   = 0;

   double_ended_queue #(.DEPTH(DEPTH)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // apply one request to the shadow deque and return the word it should produce
   function automatic deque_result_type deque_predict(
         input logic [deq_pkg::KIND_W-1:0] kind,
         input logic [deq_pkg::WORD_W-1:0] word);
      deque_result_type r;
      r.data_out = '0;
      r.status   = deq_pkg::STATUS_OK;
      if (kind == deq_pkg::KIND_PUSH_FRONT || kind == deq_pkg::KIND_PUSH_REAR) begin
         if (held >= DEPTH) begin
            // full: nothing moves
            r.status = deq_pkg::STATUS_OVERFLOW;
         end else if (kind == deq_pkg::KIND_PUSH_FRONT) begin
            front_idx = (front_idx == 0) ? DEPTH - 1 : front_idx - 1;
            deque_mem[front_idx] = word;
            held++;
         end else begin
            deque_mem[rear_idx] = word;
            rear_idx = (rear_idx == DEPTH - 1) ? 0 : rear_idx + 1;
            held++;
         end
      end else if (held == 0) begin
         // empty: all-ones word back, nothing moves
         r.status   = deq_pkg::STATUS_UNDERFLOW;
         r.data_out = deq_pkg::WORD_UNDERFLOW;
      end else if (kind == deq_pkg::KIND_POP_FRONT) begin
         r.data_out = deque_mem[front_idx];
         front_idx = (front_idx == DEPTH - 1) ? 0 : front_idx + 1;
         held--;
      end else begin
         rear_idx = (rear_idx == 0) ? DEPTH - 1 : rear_idx - 1;
         r.data_out = deque_mem[rear_idx];
         held--;
      end
      r.is_empty  = (held == 0);
      r.occupancy = deq_pkg::OCC_W'(held);
      return r;
   endfunction

   // present one request word, optionally after some idle cycles; valid stays
   // high after acceptance so back-to-back words need no second assignment
   task automatic send_request(input logic [deq_pkg::KIND_W-1:0] kind,
                               input logic [deq_pkg::WORD_W-1:0] word);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      req_tuser  <= kind;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_results.push_back(deque_predict(kind, word));
   endtask

   // hold off the sender until every predicted word has come back
   task automatic wait_drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_results.size() != 0);
   endtask

   function automatic logic [deq_pkg::WORD_W-1:0] random_word();
      case ($urandom_range(7))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return '1;
         3:       return '0;
         default: return $urandom;
      endcase
   endfunction

   // one random request, a push with the given odds, at either end
   task automatic random_request(input int push_pct);
      logic [deq_pkg::KIND_W-1:0] kind;
      if ($urandom_range(99) < push_pct)
         kind = $urandom_range(1) ? deq_pkg::KIND_PUSH_REAR : deq_pkg::KIND_PUSH_FRONT;
      else
         kind = $urandom_range(1) ? deq_pkg::KIND_POP_REAR : deq_pkg::KIND_POP_FRONT;
      send_request(kind, random_word());
   endtask

   // pops on a fresh, empty deque from both ends
   task automatic test_empty_pops();
      send_request(deq_pkg::KIND_POP_FRONT, 32'h1234_5678);
      send_request(deq_pkg::KIND_POP_REAR, 32'hffff_ffff);
   endtask

   // extreme words through both ends, then an underflow once drained
   task automatic test_extreme_words();
      send_request(deq_pkg::KIND_PUSH_FRONT, 32'h7fff_ffff);   // front wraps below index zero
      send_request(deq_pkg::KIND_PUSH_REAR,  32'h8000_0000);
      send_request(deq_pkg::KIND_PUSH_FRONT, 32'h0000_0000);
      send_request(deq_pkg::KIND_PUSH_REAR,  32'hffff_ffff);
      send_request(deq_pkg::KIND_PUSH_FRONT, 32'h5555_5555);
      send_request(deq_pkg::KIND_PUSH_REAR,  32'haaaa_aaaa);
      send_request(deq_pkg::KIND_POP_FRONT, '0);
      send_request(deq_pkg::KIND_POP_REAR,  '0);
      send_request(deq_pkg::KIND_POP_FRONT, '0);
      send_request(deq_pkg::KIND_POP_REAR,  '0);
      send_request(deq_pkg::KIND_POP_FRONT, '0);
      send_request(deq_pkg::KIND_POP_REAR,  '0);
      send_request(deq_pkg::KIND_POP_FRONT, '1);
   endtask

   // a word pushed at one end and taken from the other
   task automatic test_end_crossing();
      send_request(deq_pkg::KIND_PUSH_FRONT, 32'hdead_beef);
      send_request(deq_pkg::KIND_POP_REAR,   '0);
      send_request(deq_pkg::KIND_PUSH_REAR,  32'h0bad_f00d);
      send_request(deq_pkg::KIND_POP_FRONT,  '0);
   endtask

   // random traffic in segments: fill past full, drain past empty, mixed
   task automatic test_random_traffic(input int n_items);
      int sent;
      int extra;
      int seg;
      sent = 0;
      while (sent < n_items) begin
         case ($urandom_range(2))
            0: begin
               // mostly pushes until full, then a few overflows
               while (held < DEPTH && sent < n_items) begin
                  random_request(90);
                  sent++;
               end
               extra = $urandom_range(1, 6);
               repeat (extra) begin
                  random_request(90);
                  sent++;
               end
            end
            1: begin
               // mostly pops until empty, then a few underflows
               while (held > 0 && sent < n_items) begin
                  random_request(10);
                  sent++;
               end
               extra = $urandom_range(1, 6);
               repeat (extra) begin
                  random_request(10);
                  sent++;
               end
            end
            default: begin
               seg = $urandom_range(10, 60);
               repeat (seg) begin
                  random_request(50);
                  sent++;
               end
            end
         endcase
      end
   endtask

   // result receiver stalls at random
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // compare each accepted result word with the oldest prediction
   always @(posedge clock) begin
      deque_result_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $display("%0t: result word with none expected, data %h status %h",
                     $time, rsp_tdata, rsp_tuser);
            error_count++;
         end else begin
            exp_r = expected_results.pop_front();
            if (rsp_tdata[31:0] !== exp_r.data_out) begin
               $display("%0t: data_out expected %h actual %h",
                        $time, exp_r.data_out, rsp_tdata[31:0]);
               error_count++;
            end
            if (rsp_tuser !== exp_r.status) begin
               $display("%0t: status expected %0d actual %0d", $time, exp_r.status, rsp_tuser);
               error_count++;
            end
            if (rsp_tdata[32] !== exp_r.is_empty) begin
               $display("%0t: is_empty expected %b actual %b",
                        $time, exp_r.is_empty, rsp_tdata[32]);
               error_count++;
            end
            if (rsp_tdata[40:33] !== exp_r.occupancy) begin
               $display("%0t: occupancy expected %0d actual %0d",
                        $time, exp_r.occupancy, rsp_tdata[40:33]);
               error_count++;
            end
         end
      end
   end

   // hang detection: too long with no word moving on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= HANG_LIMIT) begin
         $display("%0t: no traffic for %0d cycles", $time, HANG_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int send_pcts [4];
      int stall_pcts [4];
      send_pcts  = '{0, 59, 0, 23};
      stall_pcts = '{0, 0, 59, 23};

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_empty_pops();
      test_extreme_words();
      test_end_crossing();
      wait_drain();

      // one random run per idling mix, sender held off until all results are back between them
      for (int p = 0; p < 4; p++) begin
         send_idle_pct  = send_pcts[p];
         recv_stall_pct = stall_pcts[p];
         test_random_traffic(450);
         wait_drain();
      end

      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
